>>> rtl/ssca_pkg.sv
// ============================================================================
// Scan sector collision avoidance: shared package
// Types, codes and arithmetic helpers used by the controller and datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package ssca_pkg;

  localparam int SectorCount = 8;

  localparam logic [15:0] FarMm       = 16'hFFFF;
  localparam logic [15:0] CritMm      = 16'd1500;
  localparam logic [15:0] BackupMm    = 16'd1000;
  localparam logic [15:0] BackNearMm  = 16'd2000;

  localparam logic [15:0] ObstacleRangeRst = 16'd3000;
  localparam logic [13:0] CruiseRateRst    = 14'd1500;
  localparam logic [13:0] TurnRateRst      = 14'd500;
  localparam logic [10:0] ScanLengthRst    = 11'd360;

  localparam logic [1:0] CfgObstacleRange = 2'd0;
  localparam logic [1:0] CfgCruiseRate    = 2'd1;
  localparam logic [1:0] CfgTurnRate      = 2'd2;
  localparam logic [1:0] CfgScanLength    = 2'd3;

  localparam logic [1:0] ZoneClear    = 2'd0;
  localparam logic [1:0] ZoneAvoid    = 2'd1;
  localparam logic [1:0] ZoneCritical = 2'd2;

  localparam logic [3:0] DivLastStep = 4'd15;
  localparam logic [3:0] MulLastStep = 4'd4;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_COMMIT  = 7'b0000010,
    ST_ZONE    = 7'b0000100,
    ST_DIVINIT = 7'b0001000,
    ST_DIV     = 7'b0010000,
    ST_MUL     = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_e;

  typedef struct packed {
    logic       sample_upd;
    logic       commit;
    logic       cmd_load;
    logic       div_init;
    logic       div_step;
    logic       div_sel;
    logic       div_last;
    logic       mul_en;
    logic [2:0] mul_cnt;
    logic       finish;
  } cmd_t;

  typedef struct packed {
    logic [1:0] zone;
  } sts_t;

  // Floor of t / 5 by reciprocal multiplication and one correction step.
  function automatic logic [15:0] div5(input logic [17:0] t);
    logic [31:0] p;
    logic [15:0] q0;
    logic [17:0] r;
    p  = 32'(t) * 32'd13107;
    q0 = p[31:16];
    r  = t - 18'(q0) * 18'd5;
    div5 = (r >= 18'd5) ? q0 + 16'd1 : q0;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) begin
      sat16 = 16'sh7FFF;
    end else if (v < -20'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/ssca_ctrl.sv
// ============================================================================
// Scan sector collision avoidance: controller
// Sequences sample folding, scan commit, division, multiply and output steps.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ssca_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_action_i,
  input  logic          in_eos_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  ssca_pkg::sts_t sts_i,
  output ssca_pkg::cmd_t cmd_o
);
  import ssca_pkg::*;

  state_e     state_q, state_d;
  logic [3:0] cnt_q, cnt_d;
  logic       sel_q, sel_d;
  logic       ov_q, ov_d;
  logic       acc;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = ov_q;
  assign acc         = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sel_d   = sel_q;
    ov_d    = ov_q & ~out_ready_i;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (in_action_i) begin
            cmd_o.cmd_load = 1'b1;
            state_d = ST_ZONE;
          end else begin
            cmd_o.sample_upd = 1'b1;
            if (in_eos_i) begin
              state_d = ST_COMMIT;
            end
          end
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d = ST_IDLE;
      end
      ST_ZONE: begin
        sel_d = 1'b0;
        state_d = (sts_i.zone == ZoneAvoid) ? ST_DIVINIT : ST_FINISH;
      end
      ST_DIVINIT: begin
        cmd_o.div_init = 1'b1;
        cmd_o.div_sel  = sel_q;
        cnt_d = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_sel  = sel_q;
        cmd_o.div_last = (cnt_q == DivLastStep);
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == DivLastStep) begin
          cnt_d = '0;
          if (!sel_q) begin
            sel_d = 1'b1;
            state_d = ST_DIVINIT;
          end else begin
            state_d = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_cnt = cnt_q[2:0];
        cnt_d = cnt_q + 4'd1;
        if (cnt_q == MulLastStep) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!ov_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          ov_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      sel_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sel_q   <= sel_d;
      ov_q    <= ov_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ssca_datapath.sv
// ============================================================================
// Scan sector collision avoidance: datapath
// Sector minima, configuration, shared divider, shared multiplier, output math.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module ssca_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ssca_pkg::cmd_t      cmd_i,
  output ssca_pkg::sts_t      sts_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [15:0]         cfg_wdata_i,
  input  logic [15:0]         range_mm_i,
  input  logic                range_valid_i,
  input  logic [9:0]          sample_index_i,
  input  logic signed [15:0]  desired_vx_i,
  input  logic signed [15:0]  desired_vy_i,
  input  logic signed [15:0]  desired_wz_i,
  output logic signed [15:0]  safe_vx_o,
  output logic signed [15:0]  safe_vy_o,
  output logic signed [15:0]  safe_wz_o,
  output logic [1:0]          zone_o
);
  import ssca_pkg::*;

  logic [15:0] obstacle_range_q;
  logic [13:0] cruise_rate_q;
  logic [13:0] turn_rate_q;
  logic [10:0] scan_length_q;

  logic [15:0] wm_q [SectorCount];
  logic [15:0] sec_q [SectorCount];
  logic [15:0] closest_q;

  logic [2:0]  sector;
  logic        in_range;
  logic [15:0] wmin;

  logic signed [15:0] vx_q, vy_q, wz_q;
  logic [1:0]  zone_q;
  logic [12:0] c_half_q;
  logic [15:0] c_clat_q, c_wlim_q, c_turn_q, c_back_q;
  logic [1:0]  zone_d;

  logic [15:0] rem_q, den_q, quo_q, sf_q, dg_q;
  logic [16:0] div_sh;
  logic        div_ge;
  logic [15:0] quo_n;

  logic [15:0] cr3;
  logic [16:0] cr7;
  logic signed [17:0] mul_a, mul_b;
  logic signed [35:0] prod_q, prod_adj;
  logic [2:0]  use_sel;
  logic signed [16:0] vxs_q, vys_q;
  logic [15:0] lat6_q, lat7_q;

  logic signed [19:0] ox, oy, ow, cr_s, wl_s;
  logic signed [15:0] safe_vx_q, safe_vy_q, safe_wz_q;
  logic [1:0]  zone_out_q;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      obstacle_range_q <= ObstacleRangeRst;
      cruise_rate_q    <= CruiseRateRst;
      turn_rate_q      <= TurnRateRst;
      scan_length_q    <= ScanLengthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgObstacleRange: obstacle_range_q <= cfg_wdata_i;
        CfgCruiseRate:    cruise_rate_q    <= cfg_wdata_i[13:0];
        CfgTurnRate:      turn_rate_q      <= cfg_wdata_i[13:0];
        CfgScanLength:    scan_length_q    <= cfg_wdata_i[10:0];
        default: ;
      endcase
    end
  end

  // The sector is the largest k with k * scan_length <= 8 * index.
  always_comb begin
    logic [13:0] kl;
    logic [13:0] idx8;
    idx8   = {1'b0, sample_index_i, 3'b000};
    sector = '0;
    for (int k = 1; k < SectorCount; k++) begin
      kl = 14'(scan_length_q) * 14'(k);
      if (idx8 >= kl) begin
        sector = 3'(k);
      end
    end
  end

  assign in_range = ({1'b0, sample_index_i} < scan_length_q);

  always_comb begin
    wmin = FarMm;
    for (int i = 0; i < SectorCount; i++) begin
      if (wm_q[i] < wmin) begin
        wmin = wm_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SectorCount; i++) begin
        wm_q[i]  <= FarMm;
        sec_q[i] <= FarMm;
      end
      closest_q <= FarMm;
    end else if (cmd_i.commit) begin
      for (int i = 0; i < SectorCount; i++) begin
        sec_q[i] <= wm_q[i];
        wm_q[i]  <= FarMm;
      end
      closest_q <= wmin;
    end else if (cmd_i.sample_upd && range_valid_i && in_range &&
                 (range_mm_i < wm_q[sector])) begin
      wm_q[sector] <= range_mm_i;
    end
  end

  // Command capture, zone and constant products.
  always_comb begin
    if (closest_q >= obstacle_range_q) begin
      zone_d = ZoneClear;
    end else if (closest_q < CritMm) begin
      zone_d = ZoneCritical;
    end else begin
      zone_d = ZoneAvoid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmd_load) begin
      vx_q     <= desired_vx_i;
      vy_q     <= desired_vy_i;
      wz_q     <= desired_wz_i;
      zone_q   <= zone_d;
      c_half_q <= cruise_rate_q[13:1];
      c_clat_q <= div5({2'b00, cruise_rate_q, 2'b00});
      c_wlim_q <= 16'((18'(turn_rate_q) * 18'd5) >> 1);
      c_turn_q <= div5(18'(turn_rate_q) * 18'd9);
      c_back_q <= div5({3'b000, cruise_rate_q, 1'b0});
    end
  end

  assign sts_o.zone = zone_q;

  // Restoring divider, one quotient bit per cycle.
  assign div_sh = {rem_q, 1'b0};
  assign div_ge = (div_sh >= {1'b0, den_q});
  assign quo_n  = {quo_q[14:0], div_ge};

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      quo_q <= '0;
      if (!cmd_i.div_sel) begin
        rem_q <= closest_q - CritMm;
        den_q <= obstacle_range_q - CritMm;
      end else begin
        rem_q <= obstacle_range_q - closest_q;
        den_q <= obstacle_range_q;
      end
    end else if (cmd_i.div_step) begin
      rem_q <= div_ge ? 16'(div_sh - {1'b0, den_q}) : div_sh[15:0];
      quo_q <= quo_n;
      if (cmd_i.div_last) begin
        if (!cmd_i.div_sel) begin
          sf_q <= quo_n;
        end else begin
          dg_q <= quo_n;
        end
      end
    end
  end

  // Shared multiplier; each product is used in the following step.
  assign cr3 = 16'(cruise_rate_q) * 16'd3;
  assign cr7 = 17'(cruise_rate_q) * 17'd7;

  always_comb begin
    case (cmd_i.mul_cnt)
      3'd0: begin
        mul_a = 18'(vx_q);
        mul_b = {2'b00, sf_q};
      end
      3'd1: begin
        mul_a = 18'(vy_q);
        mul_b = {2'b00, sf_q};
      end
      3'd2: begin
        mul_a = {2'b00, cr3};
        mul_b = {2'b00, dg_q};
      end
      3'd3: begin
        mul_a = {1'b0, cr7};
        mul_b = {2'b00, dg_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_adj = prod_q + (prod_q[35] ? 36'sd65535 : 36'sd0);
  assign use_sel  = cmd_i.mul_cnt - 3'd1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= mul_a * mul_b;
      if (cmd_i.mul_cnt != 3'd0) begin
        case (use_sel)
          3'd0: vxs_q  <= prod_adj[32:16];
          3'd1: vys_q  <= prod_adj[32:16];
          3'd2: lat6_q <= div5({2'b00, prod_q[31:16]});
          3'd3: lat7_q <= div5({2'b00, prod_q[32:17]});
          default: ;
        endcase
      end
    end
  end

  // Output command.
  assign cr_s = 20'(cruise_rate_q);
  assign wl_s = 20'(c_wlim_q);

  always_comb begin
    ox = 20'(vx_q);
    oy = 20'(vy_q);
    ow = 20'(wz_q);
    case (zone_q)
      ZoneCritical: begin
        ox = '0;
        oy = '0;
        if (closest_q < BackupMm) begin
          if (sec_q[0] < CritMm) ox = -20'(c_half_q);
          if (sec_q[2] < CritMm) oy = -20'(c_clat_q);
          if (sec_q[6] < CritMm) oy = 20'(c_clat_q);
        end
        if (sec_q[0] < obstacle_range_q) begin
          ow = (sec_q[1] > sec_q[7]) ? wl_s : -wl_s;
        end
      end
      ZoneAvoid: begin
        ox = 20'(vxs_q);
        oy = 20'(vys_q);
        if (sec_q[0] < obstacle_range_q) begin
          if (sec_q[1] > sec_q[7]) begin
            ow = ow + 20'(c_turn_q);
            oy = oy + 20'(lat6_q);
          end else begin
            ow = ow - 20'(c_turn_q);
            oy = oy - 20'(lat6_q);
          end
        end
        if (sec_q[2] < obstacle_range_q) oy = oy - 20'(lat7_q);
        if (sec_q[6] < obstacle_range_q) oy = oy + 20'(lat7_q);
        if ((sec_q[4] < obstacle_range_q) && (sec_q[4] < BackNearMm)) begin
          ox = ox + 20'(c_back_q);
        end
        if (ox > cr_s) ox = cr_s;
        if (ox < -cr_s) ox = -cr_s;
        if (oy > cr_s) oy = cr_s;
        if (oy < -cr_s) oy = -cr_s;
        if (ow > wl_s) ow = wl_s;
        if (ow < -wl_s) ow = -wl_s;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      safe_vx_q  <= sat16(ox);
      safe_vy_q  <= sat16(oy);
      safe_wz_q  <= sat16(ow);
      zone_out_q <= zone_q;
    end
  end

  assign safe_vx_o = safe_vx_q;
  assign safe_vy_o = safe_vy_q;
  assign safe_wz_o = safe_wz_q;
  assign zone_o    = zone_out_q;

endmodule

`default_nettype wire

>>> rtl/scan_sector_collision_avoidance_top.sv
// ============================================================================
// Scan sector collision avoidance: top level
// Folds lidar range samples into eight sector minima and turns velocity
// commands into safe commands with a zone code.
//
// The input stream carries two kinds of beat, told apart by tuser. A range
// sample (tuser low) produces no output; tlast marks the last sample of a
// scan and commits the sector minima. A command beat (tuser high) produces
// exactly one output beat with the safe velocity and the zone code.
// A sample that ends a scan passes through a commit step before the input
// is ready again. A clear or critical command goes from the zone check
// straight to the output step. An avoid command first makes two passes (a load
// and 16 steps each) through the shared bit-serial divider, followed by five
// steps of the shared multiplier.
// One item is in work at a time; the input is ready again as soon as the
// result sits in the output register, so a stalled receiver only blocks the
// next command when it reaches its output step. Configuration writes are
// taken on any cycle and must arrive while the block is idle.
// Reset restores the default registers and sets all distances to far.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module scan_sector_collision_avoidance_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // range_mm[15:0], range_valid[16], sample_index[26:17], desired_vx[42:27],
  // desired_vy[58:43], desired_wz[74:59], zero fill[79:75]
  input  logic [79:0] s_axis_tdata,
  // action[0]
  input  logic        s_axis_tuser,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // safe_vx[15:0], safe_vy[31:16], safe_wz[47:32], zone[49:48], zero fill[55:50]
  output logic [55:0] m_axis_tdata
);
  import ssca_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic signed [15:0] safe_vx, safe_vy, safe_wz;
  logic [1:0] zone;

  ssca_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (s_axis_tuser),
    .in_eos_i    (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ssca_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .range_mm_i     (s_axis_tdata[15:0]),
    .range_valid_i  (s_axis_tdata[16]),
    .sample_index_i (s_axis_tdata[26:17]),
    .desired_vx_i   (s_axis_tdata[42:27]),
    .desired_vy_i   (s_axis_tdata[58:43]),
    .desired_wz_i   (s_axis_tdata[74:59]),
    .safe_vx_o      (safe_vx),
    .safe_vy_o      (safe_vy),
    .safe_wz_o      (safe_wz),
    .zone_o         (zone)
  );

  assign m_axis_tdata = {6'b000000, zone, safe_wz, safe_vy, safe_vx};

endmodule

`default_nettype wire

>>> bench/tb.sv
// ============================================================================
// Scan sector collision avoidance testbench
// Streams range samples and velocity commands into the block. Each command
// result is checked field by field against an in-bench predictor with its own
// sector minima, closest distance and register copy, or against the values in
// a directed beat. Registers change while idle between phases, extremes too.
// ============================================================================
`timescale 1ns / 1ps

module tb;
  import ssca_pkg::*;

  typedef struct {
    logic        is_cmd;
    logic [15:0] range_mm;
    logic        range_ok;
    logic [9:0]  index;
    logic        last;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
    logic        typed;
    logic signed [15:0] ex_vx;
    logic signed [15:0] ex_vy;
    logic signed [15:0] ex_wz;
    logic [1:0]  ex_zone;
  } beat_t;

  typedef struct {
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] wz;
    logic [1:0]         zone;
  } safe_cmd_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_idx_i;
  logic [15:0] cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata;
  logic        s_axis_tuser;
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [55:0] m_axis_tdata;

  scan_sector_collision_avoidance_top DUT (.*);

  logic [15:0] obst_mm;
  logic [13:0] cruise;
  logic [13:0] turn;
  logic [10:0] scan_len;
  logic [15:0] work_min [SectorCount];
  logic [15:0] sector_mm [SectorCount];
  logic [15:0] nearest_mm;

  safe_cmd_t pending_cmds[$];
  int errors = 0;
  int n_samples = 0;
  int n_cmds = 0;
  int n_checked = 0;
  int n_zone [3] = '{0, 0, 0};
  int quiet_cycles = 0;
  bit steady = 0;
  bit hold_req = 0;

  initial begin
    clk_i = 0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic void fold_sample(beat_t b);
    longint s;
    if (b.range_ok && b.index < scan_len) begin
      s = (longint'(b.index) * SectorCount) / scan_len;
      if (s < SectorCount && b.range_mm < work_min[s]) work_min[s] = b.range_mm;
    end
    if (b.last) begin
      nearest_mm = FarMm;
      for (int i = 0; i < SectorCount; i++) begin
        sector_mm[i] = work_min[i];
        if (work_min[i] < nearest_mm) nearest_mm = work_min[i];
        work_min[i] = FarMm;
      end
    end
  endfunction

  function automatic safe_cmd_t predict_safe_cmd(beat_t b);
    safe_cmd_t r;
    longint vx, vy, wz, cr, tr, rng, d, sf, dg, lat6, lat7, wlim;
    longint front, fl, fr, left, right, back;
    vx = b.vx; vy = b.vy; wz = b.wz;
    cr = cruise; tr = turn; rng = obst_mm; d = nearest_mm;
    front = sector_mm[0]; fl = sector_mm[1]; left = sector_mm[2];
    back = sector_mm[4]; right = sector_mm[6]; fr = sector_mm[7];
    if (d >= rng) begin
      r.zone = ZoneClear;
    end else if (d < CritMm) begin
      r.zone = ZoneCritical;
      vx = 0;
      vy = 0;
      if (d < BackupMm) begin
        if (front < CritMm) vx = -(cr / 2);
        if (left < CritMm) vy = -((cr * 4) / 5);
        if (right < CritMm) vy = (cr * 4) / 5;
      end
      if (front < rng) wz = (fl > fr) ? (tr * 5) / 2 : -((tr * 5) / 2);
    end else begin
      r.zone = ZoneAvoid;
      sf = ((d - CritMm) << 16) / (rng - CritMm);
      dg = ((rng - d) << 16) / rng;
      vx = (vx * sf) / 65536;
      vy = (vy * sf) / 65536;
      lat6 = (cr * 3 * dg) / (5 * 65536);
      lat7 = (cr * 7 * dg) / (10 * 65536);
      if (front < rng) begin
        if (fl > fr) begin
          wz += (tr * 9) / 5;
          vy += lat6;
        end else begin
          wz -= (tr * 9) / 5;
          vy -= lat6;
        end
      end
      if (left < rng) vy -= lat7;
      if (right < rng) vy += lat7;
      if (back < rng && back < BackNearMm) vx += (cr * 2) / 5;
      wlim = (tr * 5) / 2;
      vx = clip(vx, -cr, cr);
      vy = clip(vy, -cr, cr);
      wz = clip(wz, -wlim, wlim);
    end
    r.vx = 16'(clip(vx, -32768, 32767));
    r.vy = 16'(clip(vy, -32768, 32767));
    r.wz = 16'(clip(wz, -32768, 32767));
    return r;
  endfunction

  task automatic send_beat(beat_t b);
    int gap;
    safe_cmd_t e;
    gap = steady ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= b.is_cmd;
    s_axis_tlast  <= b.last;
    s_axis_tdata  <= {5'b0, b.wz, b.vy, b.vx, b.index, b.range_ok, b.range_mm};
    do @(posedge clk_i); while (!s_axis_tready);
    if (b.is_cmd) begin
      e = predict_safe_cmd(b);
      if (b.typed) begin
        e.vx = b.ex_vx; e.vy = b.ex_vy; e.wz = b.ex_wz; e.zone = b.ex_zone;
      end
      pending_cmds = {pending_cmds, e};
      n_cmds++;
    end else begin
      fold_sample(b);
      n_samples++;
    end
  endtask

  task automatic write_regs(logic [15:0] rng, logic [13:0] cr, logic [13:0] tr,
                            logic [10:0] len);
    s_axis_tvalid <= 1'b0;
    wait (pending_cmds.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CfgObstacleRange; cfg_wdata_i <= rng;
    @(posedge clk_i);
    cfg_idx_i <= CfgCruiseRate; cfg_wdata_i <= 16'(cr);
    @(posedge clk_i);
    cfg_idx_i <= CfgTurnRate; cfg_wdata_i <= 16'(tr);
    @(posedge clk_i);
    cfg_idx_i <= CfgScanLength; cfg_wdata_i <= 16'(len);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    obst_mm = rng; cruise = cr; turn = tr; scan_len = len;
  endtask

  function automatic beat_t make_sample(logic [15:0] rmm, logic ok, logic [9:0] idx,
                                        logic last);
    beat_t b;
    b = '{default: '0};
    b.range_mm = rmm; b.range_ok = ok; b.index = idx; b.last = last;
    return b;
  endfunction

  function automatic beat_t make_cmd(logic signed [15:0] vx, logic signed [15:0] vy,
                                     logic signed [15:0] wz);
    beat_t b;
    b = '{default: '0};
    b.is_cmd = 1'b1; b.vx = vx; b.vy = vy; b.wz = wz;
    b.range_mm = 16'($urandom()); b.index = 10'($urandom());
    b.range_ok = 1'($urandom()); b.last = 1'($urandom());
    return b;
  endfunction

  function automatic logic [15:0] pick_range();
    int hi;
    hi = int'(obst_mm) + int'(obst_mm) / 2 + 1;
    if (hi > 65535) hi = 65535;
    case ($urandom_range(0, 5))
      0: return 16'($urandom());
      1: return 16'($urandom_range(0, 1600));
      default: return 16'($urandom_range(0, hi));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_speed();
    case ($urandom_range(0, 5))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 4000)) - 16'sd2000;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic random_phase(int n_items);
    int sent, k;
    logic [9:0] idx;
    sent = 0;
    while (sent < n_items) begin
      k = $urandom_range(1, 12);
      for (int i = 0; i < k; i++) begin
        if ($urandom_range(0, 9) == 0) idx = 10'($urandom());
        else idx = 10'($urandom_range(0, int'(scan_len) - 1));
        send_beat(make_sample(pick_range(), $urandom_range(0, 7) != 0, idx,
                              i == k - 1 || $urandom_range(0, 29) == 0));
      end
      sent += k;
      k = $urandom_range(1, 4);
      for (int i = 0; i < k; i++) send_beat(make_cmd(pick_speed(), pick_speed(), pick_speed()));
      sent += k;
    end
  endtask

  beat_t directed [] = '{
    '{1, 0, 0, 0, 0, 16'sh7FFF, 16'sh8000, -16'sd1, 1, 16'sh7FFF, 16'sh8000, -16'sd1, ZoneClear},
    '{1, 16'hFFFF, 1, 10'h3FF, 1, 16'sh8000, 16'sh7FFF, 16'sh7FFF,
      1, 16'sh8000, 16'sh7FFF, 16'sh7FFF, ZoneClear},
    '{0, 500, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 400, 1, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1200, 1, 45, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 900, 1, 90, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1100, 1, 270, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 65535, 1, 359, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 1000, 1000, 100, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 16'sh7FFF, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0},
    '{0, 1800, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1900, 1, 180, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 2100, 1, 320, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 65534, 1, 300, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{0, 1200, 1, 10, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, -16'sd500, 16'sd700, 16'sd300, 0, 0, 0, 0, 0},
    '{0, 100, 0, 5, 1, 0, 0, 0, 0, 0, 0, 0, 0},
    '{1, 0, 0, 0, 0, 16'sd1234, -16'sd4321, 16'sd77, 1, 16'sd1234, -16'sd4321, 16'sd77, ZoneClear}
  };

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      safe_cmd_t e;
      if (pending_cmds.size() == 0) begin
        $error("output beat with no command pending: %h", m_axis_tdata);
        errors++;
      end else begin
        e = pending_cmds.pop_front();
        n_checked++;
        if (e.zone <= ZoneCritical) n_zone[e.zone]++;
        if (m_axis_tdata[15:0] !== e.vx) begin
          $error("safe_vx expected %0d got %0d", e.vx, $signed(m_axis_tdata[15:0]));
          errors++;
        end
        if (m_axis_tdata[31:16] !== e.vy) begin
          $error("safe_vy expected %0d got %0d", e.vy, $signed(m_axis_tdata[31:16]));
          errors++;
        end
        if (m_axis_tdata[47:32] !== e.wz) begin
          $error("safe_wz expected %0d got %0d", e.wz, $signed(m_axis_tdata[47:32]));
          errors++;
        end
        if (m_axis_tdata[49:48] !== e.zone) begin
          $error("zone expected %0d got %0d", e.zone, m_axis_tdata[49:48]);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= 3000) begin
      $display("scan_sector_collision_avoidance_top test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int gap;
    forever begin
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_req = 0;
      end
      gap = steady ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  initial begin
    rst_ni <= 1'b0;
    cfg_we_i <= 1'b0;
    cfg_idx_i <= CfgObstacleRange;
    cfg_wdata_i <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    s_axis_tuser <= 1'b0;
    s_axis_tlast <= 1'b0;
    obst_mm = ObstacleRangeRst; cruise = CruiseRateRst;
    turn = TurnRateRst; scan_len = ScanLengthRst;
    for (int i = 0; i < SectorCount; i++) begin
      work_min[i] = FarMm;
      sector_mm[i] = FarMm;
    end
    nearest_mm = FarMm;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_beat(directed[i]);

    random_phase(110);
    write_regs(16'd60000, 14'd10000, 14'd10000, 11'd1024);
    steady = 1;
    random_phase(100);
    steady = 0;
    write_regs(16'd1, 14'd0, 14'd0, 11'd1);
    random_phase(60);
    write_regs(16'd2500, 14'd10000, 14'd10000, 11'd8);
    hold_req = 1;
    random_phase(110);
    write_regs(16'($urandom_range(1600, 8000)), 14'($urandom_range(0, 10000)),
               14'($urandom_range(0, 10000)), 11'($urandom_range(8, 64)));
    random_phase(110);
    s_axis_tvalid <= 1'b0;

    wait (pending_cmds.size() == 0);
    repeat (60) @(posedge clk_i);
    $display("Covered %0d range samples and %0d commands; %0d results checked.",
             n_samples, n_cmds, n_checked);
    $display("Zones seen: clear %0d, avoid %0d, critical %0d.",
             n_zone[0], n_zone[1], n_zone[2]);
    if (errors == 0) begin
      $display("scan_sector_collision_avoidance_top test passed");
    end else begin
      $display("scan_sector_collision_avoidance_top test failed");
    end
    $finish;
  end
endmodule

>>> sim.f
rtl/ssca_pkg.sv
rtl/ssca_ctrl.sv
rtl/ssca_datapath.sv
rtl/scan_sector_collision_avoidance_top.sv
bench/tb.sv
